### src/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// RC receiver frame decoder package
// Shared types and constants for the frame decoder controller and datapath.
// ----------------------------------------------------------------------------
package rcfd_pkg;

   // Frame format.
   localparam logic [7:0]  FRAME_LEN   = 8'd32;
   localparam logic [7:0]  FRAME_TYPE  = 8'h40;
   localparam logic [15:0] SUM_GOOD    = 16'hFFFF;
   localparam logic [4:0]  POS_LEN     = 5'd0;
   localparam logic [4:0]  POS_TYPE    = 5'd1;
   localparam logic [4:0]  POS_CK_LOW  = 5'd30;
   localparam logic [4:0]  POS_CK_HIGH = 5'd31;

   // Field widths.
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 5;
   localparam int CSR_IDX_W = 4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_LEN_ERR = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TYPE_ERR = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SUM_ERR = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_CHANNEL  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISARM_VALUE = 4'd1;
   localparam logic [WORD_W-1:0]    DISARM_RESET     = 16'd1000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                accept;
      logic                ld_status;
      logic [STATUS_W-1:0] status;
      logic                ld_disarm;
      logic                ld_chan;
      logic                rd_arm;
      logic                rd_chan;
      logic                idx_clr;
      logic                idx_inc;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_end;
      logic type_err;
      logic sum_err;
      logic arm_in_range;
      logic arm_match;
      logic idx_last;
      logic out_free;
   } stat_type;

endpackage

### src/rcfd_if.sv
// ----------------------------------------------------------------------------
// RC receiver frame decoder channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------

// Received serial byte channel.
interface rcfd_req_if;
   logic                        valid;
   logic                        ready;
   logic [rcfd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded result channel.
interface rcfd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rcfd_pkg::STATUS_W-1:0] frame_status;
   logic                          disarm;
   logic                          channel_valid;
   logic [rcfd_pkg::INDEX_W-1:0]  channel_index;
   logic [rcfd_pkg::WORD_W-1:0]   channel_value;
   logic                          last;

   modport source (output valid, output frame_status, output disarm,
                   output channel_valid, output channel_index,
                   output channel_value, output last, input ready);
   modport sink   (input valid, input frame_status, input disarm,
                   input channel_valid, input channel_index,
                   input channel_value, input last, output ready);
endinterface

// Configuration register write channel.
interface rcfd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [rcfd_pkg::CSR_IDX_W-1:0] index;
   logic [rcfd_pkg::WORD_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/rcfd_ctrl.sv
// ----------------------------------------------------------------------------
// RC receiver frame decoder controller
// Sequences byte intake, frame-end checks, the disarm test and channel drain.
// ----------------------------------------------------------------------------
module rcfd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rcfd_pkg::stat_type stat,
   output rcfd_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_ARM,
      S_RD,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Bytes are taken only while idle and the result register can take a beat.
   assign req_ready = (state_ff == S_IDLE) && stat.out_free;

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = rcfd_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid && req_ready;
            if (cmd.accept && stat.frame_end) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (stat.type_err || stat.sum_err) begin
               if (stat.out_free) begin
                  cmd.ld_status = 1'b1;
                  cmd.status    = stat.type_err ? rcfd_pkg::ST_TYPE_ERR
                                                : rcfd_pkg::ST_SUM_ERR;
                  state_in      = S_IDLE;
               end
            end else if (stat.arm_in_range) begin
               cmd.rd_arm = 1'b1;
               state_in   = S_ARM;
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = S_RD;
            end
         end
         S_ARM: begin
            if (stat.arm_match) begin
               if (stat.out_free) begin
                  cmd.ld_disarm = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = S_RD;
            end
         end
         S_RD: begin
            cmd.rd_chan = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.ld_chan = 1'b1;
               if (stat.idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/rcfd_dp.sv
// ----------------------------------------------------------------------------
// RC receiver frame decoder datapath
// Frame position, checksum, channel memory, configuration and result register.
// ----------------------------------------------------------------------------
module rcfd_dp #(
   parameter int CHANNELS = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rcfd_pkg::BYTE_W-1:0]     rx_byte,
   input  logic                            csr_we,
   input  logic [rcfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcfd_pkg::WORD_W-1:0]     csr_data,
   input  logic                            rsp_ready,
   input  rcfd_pkg::cmd_type               cmd,
   output rcfd_pkg::stat_type              stat,
   output logic                            rsp_valid,
   output logic [rcfd_pkg::STATUS_W-1:0]   rsp_frame_status,
   output logic                            rsp_disarm,
   output logic                            rsp_channel_valid,
   output logic [rcfd_pkg::INDEX_W-1:0]    rsp_channel_index,
   output logic [rcfd_pkg::WORD_W-1:0]     rsp_channel_value,
   output logic                            rsp_last
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [rcfd_pkg::INDEX_W-1:0] LAST_IDX =
      rcfd_pkg::INDEX_W'(CHANNELS - 1);
   localparam logic [rcfd_pkg::INDEX_W-1:0] NUM_CH = rcfd_pkg::INDEX_W'(CHANNELS);

   // Configuration registers.
   logic [rcfd_pkg::INDEX_W-1:0] arm_channel_ff;
   logic [rcfd_pkg::WORD_W-1:0]  disarm_value_ff;

   // Frame tracking.
   logic [rcfd_pkg::POS_W-1:0]  byte_pos_ff;
   logic [rcfd_pkg::POS_W-1:0]  byte_pos_in;
   logic [rcfd_pkg::WORD_W-1:0] running_sum_ff;
   logic [rcfd_pkg::WORD_W-1:0] running_sum_in;
   logic                        type_good_ff;
   logic [rcfd_pkg::BYTE_W-1:0] checksum_low_ff;
   logic [rcfd_pkg::BYTE_W-1:0] low_byte_ff;
   logic                        type_err_ff;
   logic                        sum_err_ff;

   // Channel memory and its registered read port.
   logic [rcfd_pkg::WORD_W-1:0] mem_ff [CHANNELS];
   logic [rcfd_pkg::WORD_W-1:0] rd_data_ff;
   logic [AW-1:0]               rd_addr;
   logic [rcfd_pkg::INDEX_W-1:0] idx_ff;

   // Byte decode.
   logic [rcfd_pkg::POS_W-1:0]   pos_off;
   logic [rcfd_pkg::INDEX_W-1:0] ch_num;
   logic                         in_channels;
   logic                         mem_we;
   logic                         len_err;
   logic [rcfd_pkg::WORD_W-1:0]  frame_total;

   // Result register.
   logic                          rsp_valid_ff;
   logic [rcfd_pkg::STATUS_W-1:0] status_ff;
   logic                          disarm_ff;
   logic                          chv_ff;
   logic [rcfd_pkg::INDEX_W-1:0]  chi_ff;
   logic [rcfd_pkg::WORD_W-1:0]   chval_ff;
   logic                          last_ff;

   assign pos_off     = byte_pos_ff - 5'd2;
   assign ch_num      = pos_off[rcfd_pkg::POS_W-1:1];
   assign in_channels = (byte_pos_ff > rcfd_pkg::POS_TYPE) &&
                        (byte_pos_ff < rcfd_pkg::POS_CK_LOW) && (ch_num < NUM_CH);
   assign mem_we      = cmd.accept && in_channels && byte_pos_ff[0];
   assign len_err     = cmd.accept && (byte_pos_ff == rcfd_pkg::POS_LEN) &&
                        (rx_byte != rcfd_pkg::FRAME_LEN);
   assign frame_total = running_sum_ff + {rx_byte, checksum_low_ff};

   // Position and running sum for the next byte.
   always_comb begin
      byte_pos_in    = byte_pos_ff;
      running_sum_in = running_sum_ff + {8'd0, rx_byte};
      case (byte_pos_ff)
         rcfd_pkg::POS_LEN: begin
            running_sum_in = {8'd0, rx_byte};
            byte_pos_in    = (rx_byte == rcfd_pkg::FRAME_LEN) ? 5'd1 : 5'd0;
         end
         rcfd_pkg::POS_CK_LOW: begin
            running_sum_in = running_sum_ff;
            byte_pos_in    = rcfd_pkg::POS_CK_HIGH;
         end
         rcfd_pkg::POS_CK_HIGH: begin
            running_sum_in = running_sum_ff;
            byte_pos_in    = rcfd_pkg::POS_LEN;
         end
         default: begin
            byte_pos_in = byte_pos_ff + 5'd1;
         end
      endcase
   end

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         arm_channel_ff  <= '0;
         disarm_value_ff <= rcfd_pkg::DISARM_RESET;
      end else if (csr_we) begin
         if (csr_index == rcfd_pkg::CSR_ARM_CHANNEL) begin
            arm_channel_ff <= csr_data[rcfd_pkg::INDEX_W-1:0];
         end else if (csr_index == rcfd_pkg::CSR_DISARM_VALUE) begin
            disarm_value_ff <= csr_data;
         end
      end
   end

   // Frame tracking registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= rcfd_pkg::POS_LEN;
      end else if (cmd.accept) begin
         byte_pos_ff <= byte_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         running_sum_ff <= running_sum_in;
         if (byte_pos_ff == rcfd_pkg::POS_TYPE) begin
            type_good_ff <= (rx_byte == rcfd_pkg::FRAME_TYPE);
         end
         if (byte_pos_ff == rcfd_pkg::POS_CK_LOW) begin
            checksum_low_ff <= rx_byte;
         end
         if (!byte_pos_ff[0]) begin
            low_byte_ff <= rx_byte;
         end
         if (byte_pos_ff == rcfd_pkg::POS_CK_HIGH) begin
            type_err_ff <= !type_good_ff;
            sum_err_ff  <= (frame_total != rcfd_pkg::SUM_GOOD);
         end
      end
   end

   // Channel memory: the whole word is written on its high byte.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[ch_num[AW-1:0]] <= {rx_byte, low_byte_ff};
      end
   end

   assign rd_addr = cmd.rd_arm ? arm_channel_ff[AW-1:0] : idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.rd_arm || cmd.rd_chan) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Drain index.
   always_ff @(posedge clock) begin
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 4'd1;
      end
   end

   // Result register: one beat held until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (len_err || cmd.ld_status || cmd.ld_disarm || cmd.ld_chan) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (len_err || cmd.ld_status || cmd.ld_disarm || cmd.ld_chan) begin
         status_ff <= len_err ? rcfd_pkg::ST_LEN_ERR :
                      cmd.ld_status ? cmd.status : rcfd_pkg::ST_OK;
         disarm_ff <= cmd.ld_disarm && !len_err;
         chv_ff    <= cmd.ld_chan && !len_err;
         chi_ff    <= (cmd.ld_chan && !len_err) ? idx_ff : '0;
         chval_ff  <= (cmd.ld_chan && !len_err) ? rd_data_ff : '0;
         last_ff   <= len_err || !cmd.ld_chan || (idx_ff == LAST_IDX);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_status  = status_ff;
   assign rsp_disarm        = disarm_ff;
   assign rsp_channel_valid = chv_ff;
   assign rsp_channel_index = chi_ff;
   assign rsp_channel_value = chval_ff;
   assign rsp_last          = last_ff;

   // Status toward the controller.
   assign stat.frame_end    = (byte_pos_ff == rcfd_pkg::POS_CK_HIGH);
   assign stat.type_err     = type_err_ff;
   assign stat.sum_err      = sum_err_ff;
   assign stat.arm_in_range = (arm_channel_ff < NUM_CH);
   assign stat.arm_match    = (rd_data_ff == disarm_value_ff);
   assign stat.idx_last     = (idx_ff == LAST_IDX);
   assign stat.out_free     = !rsp_valid_ff || rsp_ready;

endmodule

### src/rc_receiver_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// RC receiver frame decoder
// Decodes 32-byte servo frames into a status, a disarm flag or 14 channels.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                       Beat
//  req_ch    in         rx_byte                                       one byte
//  rsp_ch    out        frame_status disarm channel_valid             one result
//                       channel_index channel_value last
//  csr_ch    in         index data                                    one write
//
//  A byte that ends no frame is taken without the controller leaving idle.
//  The final checksum byte starts a frame-end pass: an error or disarm
//  result, or else one result per channel, each read through the single
//  registered read port of the channel memory.
//  Reset is synchronous; after it the decoder waits for a length byte.
//  A stalled result holds the result register and the controller in place.
// ----------------------------------------------------------------------------
module rc_receiver_frame_decoder_top #(
   parameter int CHANNELS = 14
) (
   input  logic       clock,
   input  logic       reset,
   rcfd_req_if.sink   req_ch,
   rcfd_rsp_if.source rsp_ch,
   rcfd_csr_if.sink   csr_ch
);

   rcfd_pkg::cmd_type  cmd;
   rcfd_pkg::stat_type stat;

   // Register writes are always taken.
   assign csr_ch.ready = 1'b1;

   rcfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rcfd_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .rx_byte           (req_ch.rx_byte),
      .csr_we            (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .rsp_ready         (rsp_ch.ready),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_ch.valid),
      .rsp_frame_status  (rsp_ch.frame_status),
      .rsp_disarm        (rsp_ch.disarm),
      .rsp_channel_valid (rsp_ch.channel_valid),
      .rsp_channel_index (rsp_ch.channel_index),
      .rsp_channel_value (rsp_ch.channel_value),
      .rsp_last          (rsp_ch.last)
   );

endmodule

### src/rcfd_checker.sv
// ----------------------------------------------------------------------------
// RC receiver frame decoder port checker
// Watches the top-level ports for result consistency over time.
// ----------------------------------------------------------------------------
module rcfd_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rcfd_pkg::STATUS_W-1:0] rsp_frame_status,
   input logic                          rsp_disarm,
   input logic                          rsp_channel_valid,
   input logic                          rsp_last
);

   // A stalled result beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // Error and disarm results always carry last.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_channel_valid |-> rsp_last)
      else $error("non-channel result without last");

   // A channel beat only comes from a good frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_channel_valid |->
         rsp_frame_status == rcfd_pkg::ST_OK && !rsp_disarm)
      else $error("channel beat on a bad or disarm frame");

   // A disarm beat carries an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_disarm |-> rsp_frame_status == rcfd_pkg::ST_OK)
      else $error("disarm beat with error status");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind rc_receiver_frame_decoder_top rcfd_port_checker u_rcfd_port_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_frame_status  (rsp_ch.frame_status),
   .rsp_disarm        (rsp_ch.disarm),
   .rsp_channel_valid (rsp_ch.channel_valid),
   .rsp_last          (rsp_ch.last)
);

### bench/rcfd_checker.sv
// ----------------------------------------------------------------------------
// RC receiver frame decoder checker
// Watches the byte, result and register channels of the decoder, keeps its
// own model of the frame parser and compares every result beat in order.
// ----------------------------------------------------------------------------
module rcfd_checker
   import rcfd_pkg::*;
#(
   parameter int CHANNELS = 14
) (
   input  logic clock,
   input  logic reset,
   rcfd_req_if  req_ch,
   rcfd_rsp_if  rsp_ch,
   rcfd_csr_if  csr_ch,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // One result beat as the decoder presents it.
   typedef struct packed {
      logic [STATUS_W-1:0] frame_status;
      logic                disarm;
      logic                channel_valid;
      logic [INDEX_W-1:0]  channel_index;
      logic [WORD_W-1:0]   channel_value;
      logic                last;
   } frame_result_type;

   // Results predicted but not yet seen, oldest first.
   frame_result_type expected_results[$];

   // Parser state and register copies.
   logic [POS_W-1:0]     frame_pos;
   logic [WORD_W-1:0]    frame_sum;
   logic                 type_ok;
   logic [BYTE_W-1:0]    ck_low;
   logic [WORD_W-1:0]    chan_word [CHANNELS];
   logic [INDEX_W-1:0]   arm_sel;
   logic [WORD_W-1:0]    disarm_word;
   int                   mismatches = 0;

   // A single-beat result that carries only a status or the disarm flag.
   function automatic frame_result_type status_result(input logic [STATUS_W-1:0] status,
                                                      input logic dis);
      frame_result_type r;
      r              = '0;
      r.frame_status = status;
      r.disarm       = dis;
      r.last         = 1'b1;
      return r;
   endfunction

   // Advance the frame parser by one received byte and queue what it causes.
   function automatic void decode_byte(input logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] checksum;
      logic [WORD_W-1:0] total;
      frame_result_type  r;
      int                ch;
      if (frame_pos == POS_LEN) begin
         if (b != FRAME_LEN) begin
            expected_results.push_back(status_result(ST_LEN_ERR, 1'b0));
         end else begin
            frame_sum = WORD_W'(b);
            frame_pos = POS_TYPE;
         end
      end else if (frame_pos == POS_TYPE) begin
         type_ok   = (b == FRAME_TYPE);
         frame_sum = frame_sum + WORD_W'(b);
         frame_pos = frame_pos + 1'b1;
      end else if (frame_pos < POS_CK_LOW) begin
         // Channel bytes: low byte at even positions, high byte at odd ones.
         ch        = (int'(frame_pos) - 2) / 2;
         frame_sum = frame_sum + WORD_W'(b);
         if (ch < CHANNELS) begin
            if (!frame_pos[0]) begin
               chan_word[ch][7:0] = b;
            end else begin
               chan_word[ch][15:8] = b;
            end
         end
         frame_pos = frame_pos + 1'b1;
      end else if (frame_pos == POS_CK_LOW) begin
         ck_low    = b;
         frame_pos = POS_CK_HIGH;
      end else begin
         // Final checksum byte: the type is judged before the checksum.
         frame_pos = POS_LEN;
         checksum  = {b, ck_low};
         total     = frame_sum + checksum;
         if (!type_ok) begin
            expected_results.push_back(status_result(ST_TYPE_ERR, 1'b0));
         end else if (total != SUM_GOOD) begin
            expected_results.push_back(status_result(ST_SUM_ERR, 1'b0));
         end else if (arm_sel < CHANNELS && chan_word[arm_sel] == disarm_word) begin
            expected_results.push_back(status_result(ST_OK, 1'b1));
         end else begin
            for (int k = 0; k < CHANNELS; k++) begin
               r               = '0;
               r.frame_status  = ST_OK;
               r.channel_valid = 1'b1;
               r.channel_index = INDEX_W'(k);
               r.channel_value = chan_word[k];
               r.last          = (k == CHANNELS - 1);
               expected_results.push_back(r);
            end
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // Sample all channels at the clock edge; results are checked before the
   // byte of the same edge is decoded so a result can never match itself.
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         frame_pos   = POS_LEN;
         frame_sum   = '0;
         type_ok     = 1'b0;
         ck_low      = '0;
         arm_sel     = '0;
         disarm_word = DISARM_RESET;
         for (int k = 0; k < CHANNELS; k++) begin
            chan_word[k] = '0;
         end
         expected_results.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t ns: result beat, expected none, actual status %0h disarm %0h",
                        $time, rsp_ch.frame_status, rsp_ch.disarm);
            end else begin
               want = expected_results.pop_front();
               check_field("frame_status", WORD_W'(want.frame_status),
                           WORD_W'(rsp_ch.frame_status));
               check_field("disarm", WORD_W'(want.disarm), WORD_W'(rsp_ch.disarm));
               check_field("channel_valid", WORD_W'(want.channel_valid),
                           WORD_W'(rsp_ch.channel_valid));
               check_field("channel_index", WORD_W'(want.channel_index),
                           WORD_W'(rsp_ch.channel_index));
               check_field("channel_value", want.channel_value, rsp_ch.channel_value);
               check_field("last", WORD_W'(want.last), WORD_W'(rsp_ch.last));
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_ARM_CHANNEL) begin
               arm_sel = csr_ch.data[INDEX_W-1:0];
            end else if (csr_ch.index == CSR_DISARM_VALUE) begin
               disarm_word = csr_ch.data;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            decode_byte(req_ch.rx_byte);
         end
      end
      pending    <= expected_results.size();
      fail_count <= mismatches;
   end

endmodule

### bench/rc_receiver_frame_decoder_top_test.sv
// ----------------------------------------------------------------------------
// RC receiver frame decoder testbench
// Sends directed and random servo frames, broken frames and noise bytes with
// random gaps and result stalls, under several register settings, and lets
// the checker compare every result beat.
// ----------------------------------------------------------------------------
module rc_receiver_frame_decoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rcfd_pkg::*;

   localparam int CHANNELS      = 14;
   localparam int FRAME_WORDS   = 14;
   localparam int FRAME_BYTES   = 32;
   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_IDLE      = 8;
   localparam int RANDOM_BYTES  = 48;
   localparam int PHASES        = 4;

   typedef enum int {
      SEG_GOOD,
      SEG_DISARM,
      SEG_TYPE_ERR,
      SEG_SUM_ERR,
      SEG_CUT,
      SEG_NOISE
   } segment_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;

   rcfd_req_if req_ch ();
   rcfd_rsp_if rsp_ch ();
   rcfd_csr_if csr_ch ();

   rc_receiver_frame_decoder_top #(
      .CHANNELS(CHANNELS)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   rcfd_checker #(
      .CHANNELS(CHANNELS)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_ch    (csr_ch),
      .fail_count(fail_count),
      .pending   (pending)
   );

   // Channel words of the next frame to send.
   logic [WORD_W-1:0]  frame_words [FRAME_WORDS];
   // Register values last written, used to build disarm frames.
   logic [INDEX_W-1:0] cfg_arm;
   logic [WORD_W-1:0]  cfg_disarm;
   int                 bytes_sent;
   int                 send_calm;
   int                 recv_calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** rc_receiver_frame_decoder_top: FAILED **");
      $finish;
   end

   // Idle cycles before the next beat, with occasional runs of no idling.
   function automatic int draw_idle(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         calm = $urandom_range(4, 24);
      end
      return $urandom_range(0, MAX_IDLE);
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = draw_idle(send_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
   endtask

   // Valid stays high so back-to-back writes run without a gap.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [WORD_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // Wait until every predicted result has arrived and the decoder is quiet.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic fill_words();
      for (int k = 0; k < FRAME_WORDS; k++) begin
         frame_words[k] = WORD_W'($urandom);
      end
   endtask

   // Build a frame from frame_words and send its first count bytes; a
   // nonzero sum_flip corrupts the checksum.
   task automatic send_frame(input logic [BYTE_W-1:0] type_byte,
                             input logic [WORD_W-1:0] sum_flip, input int count);
      logic [BYTE_W-1:0] frame [FRAME_BYTES];
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] checksum;
      frame[0] = FRAME_LEN;
      frame[1] = type_byte;
      for (int k = 0; k < FRAME_WORDS; k++) begin
         frame[2 + 2 * k] = frame_words[k][7:0];
         frame[3 + 2 * k] = frame_words[k][15:8];
      end
      sum = '0;
      for (int i = 0; i < POS_CK_LOW; i++) begin
         sum = sum + WORD_W'(frame[i]);
      end
      checksum           = ~sum ^ sum_flip;
      frame[POS_CK_LOW]  = checksum[7:0];
      frame[POS_CK_HIGH] = checksum[15:8];
      for (int i = 0; i < count; i++) begin
         send_byte(frame[i]);
      end
   endtask

   // Result side: stall a random number of cycles before each beat.
   initial begin
      int stall;
      recv_calm = 0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_idle(recv_calm);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Byte and register stimulus.
   initial begin
      int                 phase_end;
      int                 sel;
      segment_type        seg;
      logic [BYTE_W-1:0]  bad_type;
      logic [INDEX_W-1:0] arm;
      logic [WORD_W-1:0]  dis;

      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= '0;
      csr_ch.data    <= '0;
      reset          <= 1'b1;
      cfg_arm    = '0;
      cfg_disarm = DISARM_RESET;
      bytes_sent = 0;
      send_calm  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values.
      // Wrong length bytes, including one next to the right value.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h21);
      // Good frame with all-zero and all-one channel words.
      for (int k = 0; k < FRAME_WORDS; k++) begin
         frame_words[k] = k[0] ? 16'hFFFF : 16'h0000;
      end
      send_frame(FRAME_TYPE, '0, FRAME_BYTES);
      // Arm channel one off the disarm value, then exactly on it.
      fill_words();
      frame_words[0] = DISARM_RESET + 16'd1;
      send_frame(FRAME_TYPE, '0, FRAME_BYTES);
      frame_words[0] = DISARM_RESET;
      send_frame(FRAME_TYPE, '0, FRAME_BYTES);
      // Type error with a good checksum, checksum error alone, then both.
      fill_words();
      send_frame(~FRAME_TYPE, '0, FRAME_BYTES);
      send_frame(FRAME_TYPE, 16'h0001, FRAME_BYTES);
      send_frame(8'h00, 16'h8000, FRAME_BYTES);
      wait_idle();

      // Random part, one register setting per phase.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               arm = 4'd13;
               dis = 16'h0000;
            end
            1: begin
               arm = 4'd14;
               dis = 16'hFFFF;
            end
            2: begin
               arm = 4'd15;
               dis = WORD_W'($urandom);
            end
            default: begin
               arm = INDEX_W'($urandom_range(0, CHANNELS - 1));
               dis = WORD_W'($urandom);
            end
         endcase
         write_register(CSR_IDX_W'($urandom_range(2, 15)), WORD_W'($urandom));
         write_register(CSR_ARM_CHANNEL, {(WORD_W - INDEX_W)'($urandom), arm});
         write_register(CSR_DISARM_VALUE, dis);
         csr_ch.valid <= 1'b0;
         cfg_arm    = arm;
         cfg_disarm = dis;

         phase_end = bytes_sent + RANDOM_BYTES / PHASES;
         while (bytes_sent < phase_end) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) seg = SEG_GOOD;
            else if (sel < 55) seg = SEG_DISARM;
            else if (sel < 65) seg = SEG_TYPE_ERR;
            else if (sel < 75) seg = SEG_SUM_ERR;
            else if (sel < 87) seg = SEG_CUT;
            else seg = SEG_NOISE;
            fill_words();
            case (seg)
               SEG_GOOD: begin
                  // Sometimes put a near miss of the disarm value on the arm channel.
                  if (cfg_arm < CHANNELS && $urandom_range(0, 3) == 0) begin
                     frame_words[cfg_arm] = cfg_disarm ^ (16'h1 << $urandom_range(0, 15));
                  end
                  send_frame(FRAME_TYPE, '0, FRAME_BYTES);
               end
               SEG_DISARM: begin
                  if (cfg_arm < CHANNELS) begin
                     frame_words[cfg_arm] = cfg_disarm;
                  end
                  send_frame(FRAME_TYPE, '0, FRAME_BYTES);
               end
               SEG_TYPE_ERR: begin
                  bad_type = BYTE_W'($urandom);
                  if (bad_type == FRAME_TYPE) begin
                     bad_type = ~FRAME_TYPE;
                  end
                  send_frame(bad_type, $urandom_range(0, 1) ? WORD_W'($urandom) : '0,
                             FRAME_BYTES);
               end
               SEG_SUM_ERR: begin
                  send_frame(FRAME_TYPE, WORD_W'($urandom_range(1, 65535)), FRAME_BYTES);
               end
               SEG_CUT: begin
                  send_frame(FRAME_TYPE, '0, $urandom_range(1, FRAME_BYTES - 1));
               end
               default: begin
                  repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
               end
            endcase
         end
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("** rc_receiver_frame_decoder_top: PASSED **");
      end else begin
         $display("** rc_receiver_frame_decoder_top: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
src/rcfd_pkg.sv
src/rcfd_if.sv
src/rcfd_ctrl.sv
src/rcfd_dp.sv
src/rc_receiver_frame_decoder_top.sv
src/rcfd_checker.sv
bench/rcfd_checker.sv
bench/rc_receiver_frame_decoder_top_test.sv
